>>> sv/hkc_pkg.sv
`default_nettype none

package hkc_pkg;

  localparam int KEY_W            = 32;
  localparam int VAL_W            = 16;
  localparam int DIGIT_W          = 8;
  localparam int NUM_DIGITS       = KEY_W / DIGIT_W;
  localparam int DIGIT_CNT_W      = $clog2(NUM_DIGITS);
  localparam int DEF_NUM_BUCKETS  = 10;
  localparam int DEF_POOL_ENTRIES = 64;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_INSERTED  = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    VSEL_ZERO = 2'd0,
    VSEL_HOT  = 2'd1,
    VSEL_POOL = 2'd2
  } vsel_t;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] found_value;
    logic             from_hot;
  } out_item_t;

  typedef struct packed {
    logic    load;
    logic    hash_step;
    logic    head_rd;
    logic    pool_rd;
    logic    pool_from_next;
    logic    entry_wr;
    logic    head_wr;
    logic    link_wr;
    logic    used_inc;
    logic    hot_load;
    logic    finish;
    status_t status;
    vsel_t   vsel;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_insert;
    logic hot_hit;
    logic full;
    logic hash_last;
    logic head_none;
    logic rd_match;
    logic rd_next_none;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> sv/hkc_ctrl.sv
`default_nettype none

module hkc_ctrl
  import hkc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd,
  output logic     busy,
  output logic     out_valid
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_HEADCHK,
    S_WALK
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (!sts.is_insert && sts.hot_hit) begin
          cmd.finish = 1'b1;
          cmd.status = ST_FOUND;
          cmd.vsel   = VSEL_HOT;
          state_nxt  = S_IDLE;
        end else if (sts.is_insert && sts.full) begin
          cmd.finish = 1'b1;
          cmd.status = ST_FULL;
          state_nxt  = S_IDLE;
        end else begin
          cmd.hash_step = 1'b1;
          if (sts.hash_last) begin
            state_nxt = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        cmd.head_rd = 1'b1;
        state_nxt   = S_HEADCHK;
      end
      S_HEADCHK: begin
        cmd.entry_wr = sts.is_insert;
        if (sts.head_none) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
          if (sts.is_insert) begin
            cmd.head_wr  = 1'b1;
            cmd.used_inc = 1'b1;
            cmd.status   = ST_INSERTED;
          end else begin
            cmd.status = ST_NOT_FOUND;
          end
        end else begin
          cmd.pool_rd = 1'b1;
          state_nxt   = S_WALK;
        end
      end
      S_WALK: begin
        if (!sts.is_insert && sts.rd_match) begin
          cmd.hot_load = 1'b1;
          cmd.finish   = 1'b1;
          cmd.status   = ST_FOUND;
          cmd.vsel     = VSEL_POOL;
          state_nxt    = S_IDLE;
        end else if (sts.rd_next_none) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
          if (sts.is_insert) begin
            cmd.link_wr  = 1'b1;
            cmd.used_inc = 1'b1;
            cmd.status   = ST_INSERTED;
          end else begin
            cmd.status = ST_NOT_FOUND;
          end
        end else begin
          cmd.pool_rd        = 1'b1;
          cmd.pool_from_next = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> sv/hkc_dpath.sv
`default_nettype none

module hkc_dpath
  import hkc_pkg::*;
#(
  parameter int NUM_BUCKETS  = DEF_NUM_BUCKETS,
  parameter int POOL_ENTRIES = DEF_POOL_ENTRIES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  ctl_cmd_t  cmd,
  output dp_sts_t   sts,
  output out_item_t out_item
);

  localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int ACC_W  = BKT_W + DIGIT_W;
  localparam int IDX_W  = $clog2(POOL_ENTRIES);
  localparam int LINK_W = $clog2(POOL_ENTRIES + 1);
  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(POOL_ENTRIES);
  localparam logic [ACC_W-1:0]  MOD_BASE  = ACC_W'(NUM_BUCKETS);

  logic                   op_r;
  logic [KEY_W-1:0]       key_r;
  logic [VAL_W-1:0]       value_r;
  logic [KEY_W-1:0]       sr_r;
  logic [DIGIT_CNT_W-1:0] cnt_r;
  logic [BKT_W-1:0]       rem_r;
  logic [ACC_W-1:0]       hash_acc;

  logic [LINK_W-1:0]      bkt_mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] bkt_vld_r;
  logic [LINK_W-1:0]      head_q_r;
  logic                   head_vld_r;

  logic [KEY_W-1:0]       key_mem  [POOL_ENTRIES];
  logic [VAL_W-1:0]       val_mem  [POOL_ENTRIES];
  logic [LINK_W-1:0]      next_mem [POOL_ENTRIES];
  logic [KEY_W-1:0]       rd_key_r;
  logic [VAL_W-1:0]       rd_val_r;
  logic [LINK_W-1:0]      rd_next_r;
  logic [IDX_W-1:0]       cur_r;
  logic [IDX_W-1:0]       pool_addr;
  logic [IDX_W-1:0]       slot;
  logic [LINK_W-1:0]      used_r;

  logic                   hot_valid_r;
  logic [KEY_W-1:0]       hot_key_r;
  logic [VAL_W-1:0]       hot_value_r;
  out_item_t              out_r;

  // The bucket is built one byte at a time from the top, as r = (r * 256 + byte) mod N.
  always_comb begin
    hash_acc = {rem_r, sr_r[KEY_W-1 -: DIGIT_W]};
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      if (hash_acc >= (MOD_BASE << i)) begin
        hash_acc = hash_acc - (MOD_BASE << i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_item.op;
      key_r   <= in_item.key;
      value_r <= in_item.value;
      sr_r    <= in_item.key;
      cnt_r   <= '0;
      rem_r   <= '0;
    end else if (cmd.hash_step) begin
      sr_r  <= sr_r << DIGIT_W;
      cnt_r <= cnt_r + 1'b1;
      rem_r <= hash_acc[BKT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.head_wr) begin
      bkt_mem[rem_r] <= used_r;
    end
    if (cmd.head_rd) begin
      head_q_r   <= bkt_mem[rem_r];
      head_vld_r <= bkt_vld_r[rem_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bkt_vld_r <= '0;
    end else if (cmd.head_wr) begin
      bkt_vld_r[rem_r] <= 1'b1;
    end
  end

  assign pool_addr = cmd.pool_from_next ? rd_next_r[IDX_W-1:0] : head_q_r[IDX_W-1:0];
  assign slot      = used_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.entry_wr) begin
      key_mem[slot] <= key_r;
      val_mem[slot] <= value_r;
    end
    if (cmd.entry_wr) begin
      next_mem[slot] <= LINK_NONE;
    end else if (cmd.link_wr) begin
      next_mem[cur_r] <= used_r;
    end
    if (cmd.pool_rd) begin
      rd_key_r  <= key_mem[pool_addr];
      rd_val_r  <= val_mem[pool_addr];
      rd_next_r <= next_mem[pool_addr];
      cur_r     <= pool_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      hot_valid_r <= 1'b0;
    end else begin
      if (cmd.used_inc) begin
        used_r <= used_r + 1'b1;
      end
      if (cmd.hot_load) begin
        hot_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hot_load) begin
      hot_key_r   <= key_r;
      hot_value_r <= rd_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.status   <= cmd.status;
      out_r.from_hot <= (cmd.vsel == VSEL_HOT);
      case (cmd.vsel)
        VSEL_HOT:  out_r.found_value <= hot_value_r;
        VSEL_POOL: out_r.found_value <= rd_val_r;
        default:   out_r.found_value <= '0;
      endcase
    end
  end

  assign sts.is_insert    = (op_r == OP_INSERT);
  assign sts.hot_hit      = hot_valid_r && (hot_key_r == key_r);
  assign sts.full         = (used_r == LINK_NONE);
  assign sts.hash_last    = (cnt_r == DIGIT_CNT_W'(NUM_DIGITS - 1));
  assign sts.head_none    = !head_vld_r;
  assign sts.rd_match     = (rd_key_r == key_r);
  assign sts.rd_next_none = (rd_next_r == LINK_NONE);

  assign out_item = out_r;

endmodule

`default_nettype wire

>>> sv/hashed_key_cache_with_hot_entry.sv
// Channel   Ports                        Transfer
// input     start, busy, in_item         rising edge with start high and busy low
// result    out_valid, out_item          rising edge that ends the out_valid cycle
//
// A hot hit or a refused insert is answered before the bucket hash runs; a miss on an
// empty bucket follows the byte-serial bucket hash and the bucket head read, and a chain
// walk then reads the pool memory port once for each visited entry.
// Reset is synchronous and active low; it empties all buckets and the hot register.
// The result strobe lasts one cycle and cannot be held off; busy is low while it shows.
`default_nettype none

module hashed_key_cache_with_hot_entry
  import hkc_pkg::*;
#(
  parameter int NUM_BUCKETS  = DEF_NUM_BUCKETS,
  parameter int POOL_ENTRIES = DEF_POOL_ENTRIES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_item,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_item
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  hkc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  hkc_dpath #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

>>> sv/hkc_checker.sv
`default_nettype none

module hkc_checker
  import hkc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after an input transfer");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while the block is still busy");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status != ST_FOUND) |-> (out_item.found_value == '0))
    else $error("nonzero value on a result that found nothing");

  a_hot_is_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.from_hot |-> (out_item.status == ST_FOUND))
    else $error("hot flag set on a result that is not a hit");

endmodule

bind hashed_key_cache_with_hot_entry hkc_checker u_hkc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire

>>> bench/hkc_scoreboard.sv
module hkc_scoreboard
  import hkc_pkg::*;
#(
  parameter int NUM_BUCKETS  = DEF_NUM_BUCKETS,
  parameter int POOL_ENTRIES = DEF_POOL_ENTRIES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  output int        fail_count,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NO_LINK = POOL_ENTRIES;

  logic [KEY_W-1:0] slot_key   [POOL_ENTRIES];
  logic [VAL_W-1:0] slot_value [POOL_ENTRIES];
  int unsigned      slot_link  [POOL_ENTRIES];
  int unsigned      chain_head [NUM_BUCKETS];
  int unsigned      slots_used;
  logic             hot_ok;
  logic [KEY_W-1:0] hot_key_q;
  logic [VAL_W-1:0] hot_value_q;

  out_item_t        awaited_results[$];

  int n_hot_hits, n_chain_hits, n_misses, n_stored, n_refused, deepest_walk;

  function automatic void clear_cache();
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      chain_head[b] = NO_LINK;
    end
    for (int s = 0; s < POOL_ENTRIES; s++) begin
      slot_key[s]   = '0;
      slot_value[s] = '0;
      slot_link[s]  = NO_LINK;
    end
    slots_used  = 0;
    hot_ok      = 1'b0;
    hot_key_q   = '0;
    hot_value_q = '0;
  endfunction

  // Applies one request to the cache image and returns the answer it must give.
  function automatic out_item_t cache_access(in_item_t req);
    out_item_t   res;
    int unsigned bkt;
    int unsigned cur;
    int unsigned steps;
    bit          hit;
    res  = '{status: ST_NOT_FOUND, found_value: '0, from_hot: 1'b0};
    bkt  = req.key % NUM_BUCKETS;
    cur  = chain_head[bkt];
    hit  = 1'b0;
    if (req.op == OP_LOOKUP) begin
      if (hot_ok && hot_key_q == req.key) begin
        res.status      = ST_FOUND;
        res.found_value = hot_value_q;
        res.from_hot    = 1'b1;
        n_hot_hits++;
      end else begin
        for (steps = 0; steps < POOL_ENTRIES && cur < NO_LINK && !hit; steps++) begin
          if (slot_key[cur] == req.key) begin
            hit             = 1'b1;
            hot_ok          = 1'b1;
            hot_key_q       = req.key;
            hot_value_q     = slot_value[cur];
            res.status      = ST_FOUND;
            res.found_value = slot_value[cur];
          end else begin
            cur = slot_link[cur];
          end
        end
        if (steps > deepest_walk) deepest_walk = steps;
        if (hit) n_chain_hits++;
        else n_misses++;
      end
    end else if (slots_used >= POOL_ENTRIES) begin
      res.status = ST_FULL;
      n_refused++;
    end else begin
      slot_key[slots_used]   = req.key;
      slot_value[slots_used] = req.value;
      slot_link[slots_used]  = NO_LINK;
      if (cur >= NO_LINK) begin
        chain_head[bkt] = slots_used;
      end else begin
        for (steps = 0; steps < POOL_ENTRIES && slot_link[cur] < NO_LINK; steps++) begin
          cur = slot_link[cur];
        end
        slot_link[cur] = slots_used;
      end
      slots_used++;
      res.status = ST_INSERTED;
      n_stored++;
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    int        errs;
    out_item_t want;
    errs = 0;
    if (!rst_n) begin
      clear_cache();
      awaited_results.delete();
    end else begin
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $error("Result transfer with no request outstanding: status %0d, value 0x%04h.",
                 out_item.status, out_item.found_value);
          errs++;
        end else begin
          want = awaited_results.pop_front();
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item.status);
            errs++;
          end
          if (out_item.found_value !== want.found_value) begin
            $error("found_value: expected 0x%04h, got 0x%04h",
                   want.found_value, out_item.found_value);
            errs++;
          end
          if (out_item.from_hot !== want.from_hot) begin
            $error("from_hot: expected %0b, got %0b", want.from_hot, out_item.from_hot);
            errs++;
          end
        end
      end
      if (start && !busy) begin
        awaited_results.push_back(cache_access(in_item));
      end
    end
    fail_count  <= fail_count + errs;
    outstanding <= awaited_results.size();
  end

  function automatic void show_summary();
    $display("Lookups: %0d hot-register hits, %0d chain hits, %0d misses, longest walk %0d.",
             n_hot_hits, n_chain_hits, n_misses, deepest_walk);
    $display("Inserts: %0d stored, %0d refused with the pool full.", n_stored, n_refused);
  endfunction

endmodule

>>> bench/hashed_key_cache_with_hot_entry_test.sv
module hashed_key_cache_with_hot_entry_test
  import hkc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 735;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_WAIT  = 80;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;
  int        fail_count;
  int        outstanding;
  int        cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  hashed_key_cache_with_hot_entry dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  hkc_scoreboard chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  task automatic send_req(input op_t op, input logic [KEY_W-1:0] key,
                          input logic [VAL_W-1:0] value);
    start   <= 1'b1;
    in_item <= '{op: op, key: key, value: value};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Run stopped after %0d cycles without finishing.", cycle_count);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [KEY_W-1:0] stored_keys[$];
    logic [KEY_W-1:0] last_lookup;
    logic [KEY_W-1:0] key;
    op_t              op;
    int               burst_left;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(OP_LOOKUP, 32'h0000_0000, 16'hFFFF);
    send_req(OP_INSERT, 32'h0000_0000, 16'hFFFF);
    send_req(OP_INSERT, 32'hFFFF_FFFF, 16'h0000);
    idle_cycles(3);
    send_req(OP_LOOKUP, 32'hFFFF_FFFF, 16'h0000);
    send_req(OP_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF);
    send_req(OP_INSERT, 32'd10, 16'h1234);
    send_req(OP_INSERT, 32'd20, 16'hA5A5);
    send_req(OP_INSERT, 32'd10, 16'h5A5A);
    idle_cycles(1);
    send_req(OP_LOOKUP, 32'd10, 16'h0000);
    send_req(OP_LOOKUP, 32'd10, 16'h0000);
    send_req(OP_LOOKUP, 32'd30, 16'h0000);
    send_req(OP_LOOKUP, 32'd0, 16'h0000);
    send_req(OP_LOOKUP, 32'd20, 16'h0000);
    send_req(OP_INSERT, 32'd7, 16'h8001);
    send_req(OP_LOOKUP, 32'd7, 16'h7FFE);
    send_req(OP_LOOKUP, 32'd17, 16'h0000);
    send_req(OP_INSERT, 32'hFFFF_FFF6, 16'hFFFF);
    send_req(OP_LOOKUP, 32'hFFFF_FFF6, 16'h0000);
    send_req(OP_LOOKUP, 32'd10, 16'h0000);
    stored_keys = '{32'h0, 32'hFFFF_FFFF, 32'd10, 32'd20, 32'd7, 32'hFFFF_FFF6};
    last_lookup = 32'd10;
    burst_left  = 0;

    // Inserts are a minority, so the pool fills part way through and the later
    // lookups walk long chains while further inserts are refused.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 250 == 0) drain();
      if (burst_left == 0) begin
        idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      if ($urandom_range(0, 99) < 18) begin
        op = OP_INSERT;
        case ($urandom_range(0, 9))
          0, 1, 2: key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
          3, 4, 5, 6: key = 32'($urandom_range(0, 429496728) * 10 + $urandom_range(2, 4));
          default: key = $urandom;
        endcase
        stored_keys.push_back(key);
      end else begin
        op = OP_LOOKUP;
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8:
            key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
          9, 10, 11, 12: key = last_lookup;
          13, 14, 15: key = stored_keys[$urandom_range(0, stored_keys.size() - 1)] + 32'd10;
          default: key = $urandom;
        endcase
        last_lookup = key;
      end
      send_req(op, key, 16'($urandom));
    end

    drain();
    idle_cycles(SETTLE_WAIT);
    chk.show_summary();
    if (fail_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
